[hw/rtl/bcd_pkg.sv]
// ----------------------------------------------------------------------------
// Base58Check decoder package
// Frame sizes, status codes, alphabet decode and the SHA-256 constants.
// ----------------------------------------------------------------------------
package bcd_pkg;

  localparam int FRAME_BYTES = 25;
  localparam int HASH_BYTES  = 20;
  localparam int RADIX       = 58;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADCHAR = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_LONG    = 3'd3;
  localparam logic [2:0] ST_CHECK   = 3'd4;

  localparam logic [7:0] ONE_CHAR = 8'h31;

  typedef struct packed {
    logic       ok;
    logic [5:0] value;
  } digit_t;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Map one ASCII character to its digit value in the Base58 alphabet.
  function automatic digit_t decode_char(input logic [7:0] ch);
    digit_t r;
    logic [7:0] v;
    r = '0;
    v = 8'd0;
    if (ch >= 8'h31 && ch <= 8'h39) begin
      v = ch - 8'h31;
      r.ok = 1'b1;
    end else if (ch >= 8'h41 && ch <= 8'h48) begin
      v = ch - 8'h41 + 8'd9;
      r.ok = 1'b1;
    end else if (ch >= 8'h4a && ch <= 8'h4e) begin
      v = ch - 8'h4a + 8'd17;
      r.ok = 1'b1;
    end else if (ch >= 8'h50 && ch <= 8'h5a) begin
      v = ch - 8'h50 + 8'd22;
      r.ok = 1'b1;
    end else if (ch >= 8'h61 && ch <= 8'h6b) begin
      v = ch - 8'h61 + 8'd33;
      r.ok = 1'b1;
    end else if (ch >= 8'h6d && ch <= 8'h7a) begin
      v = ch - 8'h6d + 8'd44;
      r.ok = 1'b1;
    end
    r.value = v[5:0];
    return r;
  endfunction

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

[hw/rtl/bcd_sha256.sv]
// ----------------------------------------------------------------------------
// SHA-256 single block core
// One compression round per cycle over a 16-word schedule shift register.
// ----------------------------------------------------------------------------
module bcd_sha256 import bcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [511:0] block,
  output logic         done,
  output logic [255:0] digest
);

  logic [31:0] w [16];
  logic [31:0] a, b, c, d, e, f, g, hh;
  logic [5:0]  cnt;
  logic        run;
  logic        fin;

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm0, sm1, w_next;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  always_comb begin
    big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
    ch     = (e & f) ^ (~e & g);
    t1     = hh + big_s1 + ch + round_const(cnt) + w[0];
    big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
    maj    = (a & b) ^ (a & c) ^ (b & c);
    t2     = big_s0 + maj;
    sm0    = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    sm1    = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    w_next = w[0] + sm0 + w[9] + sm1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        fin <= 1'b0;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath: load on start, advance one round per cycle, fold in the IV at the end.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int j = 0; j < 16; j++) w[j] <= block[511 - 32*j -: 32];
      a <= SHA_IV[0]; b <= SHA_IV[1]; c <= SHA_IV[2]; d <= SHA_IV[3];
      e <= SHA_IV[4]; f <= SHA_IV[5]; g <= SHA_IV[6]; hh <= SHA_IV[7];
    end else if (run) begin
      for (int j = 0; j < 15; j++) w[j] <= w[j+1];
      w[15] <= w_next;
      hh <= g; g <= f; f <= e; e <= d + t1;
      d <= c; c <= b; b <= a; a <= t1 + t2;
    end else if (fin) begin
      digest <= {SHA_IV[0] + a, SHA_IV[1] + b, SHA_IV[2] + c, SHA_IV[3] + d,
                 SHA_IV[4] + e, SHA_IV[5] + f, SHA_IV[6] + g, SHA_IV[7] + hh};
    end
  end

endmodule

[hw/rtl/base58check_address_decoder_top.sv]
// ----------------------------------------------------------------------------
// Base58Check address decoder
// Folds characters into a 25-byte store, checks length and double SHA-256
// checksum, then streams the version and hash bytes or one error result.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | symbol[7:0], last
//  out     | out_valid/out_stall| status[2:0], byte_index[4:0], data_byte[7:0],
//          |                    | end_of_result
//
//  A leading '1', a bad character or a character after an error is only
//  accepted; any other character is also folded in by the byte-serial
//  multiply by 58, which walks the store one byte a cycle through a rotating
//  shift register. After the last character the two SHA-256 passes run one
//  round a cycle, then 21 results leave one a cycle while out_stall is low.
//  Reset is synchronous and clears the store and all counters at once.
//  in_stall is high whenever the block is not waiting for a character; an
//  output register holds each result until out_stall drops.
// ----------------------------------------------------------------------------
module base58check_address_decoder_top import bcd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [4:0] byte_index,
  output logic [7:0] data_byte,
  output logic       end_of_result
);

  localparam logic [2:0] S_IN   = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_SHA1 = 3'd3;
  localparam logic [2:0] S_SHA2 = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;
  localparam logic [2:0] S_ERR  = 3'd6;

  logic [2:0] state;

  // Store and per-string bookkeeping
  logic [7:0] vb [FRAME_BYTES];
  logic [4:0] leading_ones;
  logic       in_leading_run;
  logic [4:0] significant_bytes;
  logic [2:0] error_code;
  logic       last_held;

  // Multiply walk
  logic [4:0] mcnt;
  logic [5:0] carry;
  logic [4:0] sig_acc;
  logic [13:0] prod;

  // Ending
  logic [2:0] fin_status;
  logic [4:0] eidx;
  logic [5:0] total;
  logic [2:0] fin_calc;

  digit_t     dig;
  logic       accept_in;
  logic       slot_free;
  logic       emit_now;
  logic       lead_now;
  logic [4:0] lo_inc;

  logic         sha_start;
  logic [511:0] sha_block;
  logic [511:0] blk1;
  logic         sha_done;
  logic [255:0] sha_digest;

  assign in_stall  = (state != S_IN);
  assign accept_in = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign emit_now  = ((state == S_EMIT) || (state == S_ERR)) && slot_free;

  assign dig      = decode_char(symbol);
  assign lead_now = in_leading_run && (symbol == ONE_CHAR);
  assign lo_inc   = (leading_ones < 5'(FRAME_BYTES + 1)) ? leading_ones + 5'd1 : leading_ones;

  assign prod = 14'(vb[FRAME_BYTES-1]) * 14'(RADIX) + 14'(carry);

  assign total = {1'b0, leading_ones} + {1'b0, significant_bytes};

  always_comb begin
    fin_calc = error_code;
    if (error_code == ST_OK) begin
      if (total < 6'(FRAME_BYTES))      fin_calc = ST_SHORT;
      else if (total > 6'(FRAME_BYTES)) fin_calc = ST_LONG;
    end
  end

  // First block: the 21 payload bytes, the pad marker and a length of 168 bits.
  always_comb begin
    blk1 = '0;
    for (int j = 0; j <= HASH_BYTES; j++) blk1[511 - 8*j -: 8] = vb[j];
    blk1[511 - 8*(HASH_BYTES+1) -: 8] = 8'h80;
    blk1[15:0] = 16'd168;
  end

  assign sha_start = (state == S_FIN && fin_calc == ST_OK) || (state == S_SHA1 && sha_done);
  assign sha_block = (state == S_FIN) ? blk1 : {sha_digest, 8'h80, 232'd0, 16'd256};

  bcd_sha256 u_sha (
    .clk    (clk),
    .rst    (rst),
    .start  (sha_start),
    .block  (sha_block),
    .done   (sha_done),
    .digest (sha_digest)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IN;
      leading_ones      <= '0;
      in_leading_run    <= 1'b1;
      significant_bytes <= '0;
      error_code        <= ST_OK;
      for (int j = 0; j < FRAME_BYTES; j++) vb[j] <= '0;
      out_valid         <= 1'b0;
      mcnt              <= '0;
      eidx              <= '0;
    end else begin
      // Raise valid with each new result, drop it once the last one is taken
      if (emit_now) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IN: begin
          if (accept_in) begin
            last_held <= last;
            if (symbol != ONE_CHAR) in_leading_run <= 1'b0;
            if (!dig.ok) begin
              error_code <= ST_BADCHAR;
              state      <= last ? S_FIN : S_IN;
            end else if (error_code == ST_OK && lead_now) begin
              leading_ones <= lo_inc;
              if (lo_inc > 5'(FRAME_BYTES)) error_code <= ST_LONG;
              state <= last ? S_FIN : S_IN;
            end else if (error_code == ST_OK) begin
              // Start the walk from the least significant byte
              carry   <= dig.value;
              mcnt    <= '0;
              sig_acc <= '0;
              state   <= S_MUL;
            end else begin
              state <= last ? S_FIN : S_IN;
            end
          end
        end
        S_MUL: begin
          // Rotate the store: take the low byte out, put the new byte in on top
          for (int j = 1; j < FRAME_BYTES; j++) vb[j] <= vb[j-1];
          vb[0] <= prod[7:0];
          carry <= prod[13:8];
          if (prod[7:0] != 8'd0) sig_acc <= mcnt + 5'd1;
          mcnt <= mcnt + 5'd1;
          if (mcnt == 5'(FRAME_BYTES - 1)) begin
            if (prod[13:8] != 6'd0) begin
              error_code <= ST_LONG;
            end else if (prod[7:0] != 8'd0) begin
              significant_bytes <= mcnt + 5'd1;
            end else begin
              significant_bytes <= sig_acc;
            end
            state <= last_held ? S_FIN : S_IN;
          end
        end
        S_FIN: begin
          fin_status <= fin_calc;
          state      <= (fin_calc == ST_OK) ? S_SHA1 : S_ERR;
        end
        S_SHA1: begin
          if (sha_done) state <= S_SHA2;
        end
        S_SHA2: begin
          if (sha_done) begin
            eidx <= '0;
            if (sha_digest[255:224] != {vb[21], vb[22], vb[23], vb[24]}) begin
              fin_status <= ST_CHECK;
              state      <= S_ERR;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            status        <= ST_OK;
            byte_index    <= eidx;
            data_byte     <= vb[0];
            end_of_result <= (eidx == 5'(HASH_BYTES));
            eidx <= eidx + 5'd1;
            if (eidx == 5'(HASH_BYTES)) begin
              for (int j = 0; j < FRAME_BYTES; j++) vb[j] <= '0;
              leading_ones      <= '0;
              in_leading_run    <= 1'b1;
              significant_bytes <= '0;
              error_code        <= ST_OK;
              state             <= S_IN;
            end else begin
              for (int j = 0; j < FRAME_BYTES - 1; j++) vb[j] <= vb[j+1];
            end
          end
        end
        S_ERR: begin
          if (slot_free) begin
            status            <= fin_status;
            byte_index        <= '0;
            data_byte         <= '0;
            end_of_result     <= 1'b1;
            for (int j = 0; j < FRAME_BYTES; j++) vb[j] <= '0;
            leading_ones      <= '0;
            in_leading_run    <= 1'b1;
            significant_bytes <= '0;
            error_code        <= ST_OK;
            state             <= S_IN;
          end
        end
        default: state <= S_IN;
      endcase
    end
  end

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// Base58Check address decoder testbench
// Sends address strings one character per transaction: well-formed addresses
// built here with their own double SHA-256 checksum, corrupted ones, runs of
// '1', overflowing strings and bad characters. A local model or a hand-typed
// status predicts each result; each accepted one is checked field by field.
// ----------------------------------------------------------------------------
module tb_top import bcd_pkg::*; ;

  timeunit 1ns;
  timeprecision 1ps;

  localparam string ALPHABET =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
  localparam int RANDOM_CHARS = 60;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 300;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] SHA_H0 [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef struct {
    logic [7:0] sym;
    logic       fin;
    logic       fixed;   // expected status typed in by hand
    logic [2:0] fixed_st;
  } char_t;

  typedef struct {
    logic [2:0] st;
    logic [4:0] idx;
    logic [7:0] data;
    logic       eor;
  } decoded_t;

  typedef struct {
    string      text;
    int         rep;
    int         bad_pos;
    logic [7:0] bad_val;
    int         fill;    // >= 0: send a well-formed address filled with this byte
    logic       fixed;
    logic [2:0] fixed_st;
  } row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] symbol;
  logic       last;
  logic       out_valid;
  logic       out_stall;
  logic [2:0] status;
  logic [4:0] byte_index;
  logic [7:0] data_byte;
  logic       end_of_result;

  char_t    char_q[$];
  decoded_t decoded_q[$];
  char_t    cur_char;
  logic     quiet;
  int       errors;
  int       dir_chars;

  // model state for the string in flight
  logic [7:0] acc [FRAME_BYTES];
  logic [4:0] lead_cnt;
  logic       in_lead;
  logic [4:0] sig_bytes;
  logic [2:0] sticky_err;

  base58check_address_decoder_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .symbol(symbol), .last(last),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .byte_index(byte_index), .data_byte(data_byte), .end_of_result(end_of_result)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // SHA-256 of a message short enough for one block
  function automatic logic [255:0] sha_one_block(input logic [7:0] msg [64], input int len);
    logic [7:0]  blk [64];
    logic [31:0] w [64];
    logic [31:0] h [8];
    logic [31:0] a, b, c, d, e, f, g, k, t1, t2, s0, s1;
    for (int i = 0; i < 64; i++) blk[i] = (i < len) ? msg[i] : 8'h00;
    blk[len] = 8'h80;
    blk[62] = 8'((len * 8) >> 8);
    blk[63] = 8'(len * 8);
    for (int i = 0; i < 16; i++) w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++) begin
      s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    h = SHA_H0;
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; k = h[7];
    for (int i = 0; i < 64; i++) begin
      t1 = k + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) + SHA_K[i] + w[i];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      k = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
    end
    return {h[0] + a, h[1] + b, h[2] + c, h[3] + d, h[4] + e, h[5] + f, h[6] + g, h[7] + k};
  endfunction

  // first four bytes of the double SHA-256 over the version and hash bytes
  function automatic logic [31:0] check_word(input logic [7:0] frame [FRAME_BYTES]);
    logic [7:0]   msg [64];
    logic [255:0] dig;
    for (int i = 0; i < 64; i++) msg[i] = (i <= HASH_BYTES) ? frame[i] : 8'h00;
    dig = sha_one_block(msg, HASH_BYTES + 1);
    for (int i = 0; i < 32; i++) msg[i] = dig[255 - 8*i -: 8];
    dig = sha_one_block(msg, 32);
    return dig[255 -: 32];
  endfunction

  function automatic int digit_of(input logic [7:0] ch);
    for (int i = 0; i < RADIX; i++) if (ALPHABET[i] == ch) return i;
    return -1;
  endfunction

  function automatic void clear_decoder();
    foreach (acc[i]) acc[i] = 8'h00;
    lead_cnt = '0;
    in_lead = 1'b1;
    sig_bytes = '0;
    sticky_err = ST_OK;
  endfunction

  // Fold one character into the model and queue any results it causes.
  function automatic void decode_char_model(input logic [7:0] ch, input logic fin);
    int          dv;
    int          carry;
    int          x;
    int          total;
    logic [2:0]  st;
    logic [7:0]  frame [FRAME_BYTES];
    dv = digit_of(ch);
    if (ch != ONE_CHAR) in_lead = 1'b0;
    if (dv < 0) begin
      sticky_err = ST_BADCHAR;
    end else if (sticky_err == ST_OK) begin
      if (in_lead) begin
        if (lead_cnt < FRAME_BYTES + 1) lead_cnt++;
        if (lead_cnt > FRAME_BYTES) sticky_err = ST_LONG;
      end else begin
        carry = dv;
        for (int i = FRAME_BYTES - 1; i >= 0; i--) begin
          x = acc[i] * RADIX + carry;
          acc[i] = 8'(x);
          carry = x >> 8;
        end
        if (carry != 0) begin
          sticky_err = ST_LONG;
        end else begin
          sig_bytes = 5'(FRAME_BYTES);
          for (int i = 0; i < FRAME_BYTES && acc[i] == 8'h00; i++) sig_bytes--;
        end
      end
    end
    if (!fin) return;
    st = sticky_err;
    if (st == ST_OK) begin
      total = lead_cnt + sig_bytes;
      if (total < FRAME_BYTES) st = ST_SHORT;
      else if (total > FRAME_BYTES) st = ST_LONG;
    end
    if (st == ST_OK) begin
      frame = acc;
      if (check_word(frame) != {acc[21], acc[22], acc[23], acc[24]}) st = ST_CHECK;
    end
    if (st != ST_OK) begin
      decoded_q.insert(decoded_q.size(), decoded_t'{st, 5'd0, 8'h00, 1'b1});
    end else begin
      for (int i = 0; i <= HASH_BYTES; i++)
        decoded_q.insert(decoded_q.size(),
                         decoded_t'{ST_OK, 5'(i), acc[i], i == HASH_BYTES});
    end
    clear_decoder();
  endfunction

  // Build a well-formed address and return its characters.
  function automatic void make_address(input logic [7:0] frame_in [FRAME_BYTES],
                                       ref logic [7:0] text[$]);
    logic [7:0] frame [FRAME_BYTES];
    int         num [FRAME_BYTES];
    int         zeros;
    int         rem;
    int         cur;
    logic       nonzero;
    logic [31:0] cw;
    frame = frame_in;
    cw = check_word(frame);
    {frame[21], frame[22], frame[23], frame[24]} = cw;
    text.delete();
    zeros = 0;
    while (zeros < FRAME_BYTES && frame[zeros] == 8'h00) zeros++;
    foreach (num[i]) num[i] = frame[i];
    nonzero = 1'b1;
    while (nonzero) begin
      rem = 0;
      nonzero = 1'b0;
      for (int i = 0; i < FRAME_BYTES; i++) begin
        cur = rem * 256 + num[i];
        num[i] = cur / RADIX;
        rem = cur % RADIX;
        if (num[i] != 0) nonzero = 1'b1;
      end
      if (nonzero || rem != 0) text.push_front(ALPHABET[rem]);
    end
    repeat (zeros) text.push_front(ONE_CHAR);
  endfunction

  function automatic void queue_text(ref logic [7:0] text[$], input logic fixed,
                                     input logic [2:0] fixed_st);
    foreach (text[i])
      char_q.insert(char_q.size(), char_t'{text[i], i == text.size() - 1, fixed, fixed_st});
  endfunction

  function automatic logic [7:0] rand_alpha();
    return ALPHABET[$urandom_range(0, RADIX - 1)];
  endfunction

  // Directed strings: extremes, each error kind and the leading '1' run limits.
  row_t rows [] = '{
    '{"1",  1, -1, 8'h00, -1, 1'b1, ST_SHORT},
    '{"z",  1, -1, 8'h00, -1, 1'b1, ST_SHORT},
    '{"1",  1,  0, 8'h00, -1, 1'b1, ST_BADCHAR},
    '{"0",  1, -1, 8'h00, -1, 1'b1, ST_BADCHAR},
    '{"2OIl", 1, -1, 8'h00, -1, 1'b1, ST_BADCHAR},
    '{"1", 26, -1, 8'h00, -1, 1'b1, ST_LONG},
    '{"1", 27, 26, 8'hff, -1, 1'b1, ST_BADCHAR},
    '{"1", 25, -1, 8'h00, -1, 1'b0, ST_OK},
    '{"z", 36, -1, 8'h00, -1, 1'b1, ST_LONG},
    '{"",   0, -1, 8'h00, 8'h00, 1'b0, ST_OK},
    '{"",   0, -1, 8'h00, 8'hff, 1'b0, ST_OK},
    '{"",   0, 10, 8'h7a, 8'h5a, 1'b0, ST_OK}
  };

  function automatic void build_stimulus();
    logic [7:0] text[$];
    logic [7:0] frame [FRAME_BYTES];
    int         kind;
    int         pos;
    int         nz;
    foreach (rows[r]) begin
      text.delete();
      if (rows[r].fill >= 0) begin
        foreach (frame[i]) frame[i] = 8'(rows[r].fill);
        make_address(frame, text);
      end else begin
        repeat (rows[r].rep)
          for (int i = 0; i < rows[r].text.len(); i++)
            text.insert(text.size(), rows[r].text[i]);
      end
      if (rows[r].bad_pos >= 0 && rows[r].bad_pos < text.size())
        text[rows[r].bad_pos] = rows[r].bad_val;
      queue_text(text, rows[r].fixed, rows[r].fixed_st);
    end
    dir_chars = char_q.size();
    // well-formed addresses with random content, mixed with damaged ones, noise and '1' runs
    while (char_q.size() < dir_chars + RANDOM_CHARS) begin
      kind = $urandom_range(0, 9);
      text.delete();
      if (kind <= 7) begin
        foreach (frame[i]) frame[i] = 8'($urandom);
        if ($urandom_range(0, 2) == 0) frame[0] = 8'h00;
        if ($urandom_range(0, 4) == 0) begin
          nz = $urandom_range(1, 4);
          for (int i = 0; i < nz; i++) frame[i] = 8'h00;
        end
        make_address(frame, text);
        pos = $urandom_range(0, text.size() - 1);
        case (kind)
          5: text[pos] = rand_alpha();
          6: text.delete(pos);
          7: text.insert(pos, rand_alpha());
          default: ;
        endcase
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 8))
          text.insert(text.size(),
                      ($urandom_range(0, 3) == 0) ? 8'($urandom) : rand_alpha());
      end else begin
        repeat ($urandom_range(1, 27)) text.insert(text.size(), ONE_CHAR);
        repeat ($urandom_range(0, 6)) text.insert(text.size(), rand_alpha());
      end
      queue_text(text, 1'b0, ST_OK);
    end
  endfunction

  // Input side: drive at the falling edge, hold until the transaction is taken.
  initial begin
    int n_chars;
    rst = 1'b1;
    in_valid = 1'b0;
    symbol = 8'h00;
    last = 1'b0;
    quiet = 1'b0;
    errors = 0;
    clear_decoder();
    build_stimulus();
    n_chars = char_q.size();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int n = 0; n < n_chars; n++) begin
      @(negedge clk);
      // hold off once until the directed results have all drained
      if (n == dir_chars && decoded_q.size() != 0) begin
        in_valid <= 1'b0;
        while (decoded_q.size() != 0) @(negedge clk);
      end
      if (n > n_chars * 85 / 100) quiet <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end
      cur_char = char_q[n];
      in_valid <= 1'b1;
      symbol <= char_q[n].sym;
      last <= char_q[n].fin;
      do @(posedge clk); while (in_stall);
    end
    @(negedge clk);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Output side: stall in random bursts until the quiet tail.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Predict on every accepted character; hand-typed rows replace the final result.
  always @(posedge clk) begin
    int before_cnt;
    if (!rst && in_valid && !in_stall) begin
      before_cnt = decoded_q.size();
      decode_char_model(symbol, last);
      if (cur_char.fixed && last) begin
        while (decoded_q.size() > before_cnt) void'(decoded_q.pop_back());
        decoded_q.insert(decoded_q.size(),
                         decoded_t'{cur_char.fixed_st, 5'd0, 8'h00, 1'b1});
      end
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    decoded_t want;
    if (!rst && out_valid && !out_stall) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d byte_index=%0d data_byte=%02h eor=%0b",
                 $time, status, byte_index, data_byte, end_of_result);
        errors++;
      end else begin
        want = decoded_q.pop_front();
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          errors++;
        end
        if (byte_index !== want.idx) begin
          $display("%0t: byte_index expected %0d actual %0d", $time, want.idx, byte_index);
          errors++;
        end
        if (data_byte !== want.data) begin
          $display("%0t: data_byte expected %02h actual %02h", $time, want.data, data_byte);
          errors++;
        end
        if (end_of_result !== want.eor) begin
          $display("%0t: end_of_result expected %0b actual %0b", $time, want.eor,
                   end_of_result);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up after a long run of cycles with no transaction on either side.
  always @(posedge clk) begin
    int idle_cycles;
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

endmodule

[sim.f]
hw/rtl/bcd_pkg.sv
hw/rtl/bcd_sha256.sv
hw/rtl/base58check_address_decoder_top.sv
dv/tb_top.sv
